// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the shuffle engine RTL.
// Every user module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset.
`define ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ioshuf_pkg.sv -----
// Shared types and constants of the inside-out shuffle engine.
// No dependencies; used by every module of the block but ioshuf_ram.
`default_nettype none

package ioshuf_pkg;

    localparam int DATA_W        = 32;
    localparam int WORD_W        = 31;
    localparam int IDX_W         = 6;
    localparam int CMD_W         = 2;
    localparam int MAX_ELEMS_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SHUFFLE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] element_value;
        logic                     load_last;
        logic [WORD_W-1:0]        random_word;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic [IDX_W-1:0]         out_index;
        logic                     out_shuffled;
        logic                     out_last;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_EMIT_START,
        OP_COPY_START,
        OP_COPY,
        OP_RD_I,
        OP_RD_J,
        OP_WR_I,
        OP_WR_J,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   mod_start;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             len_zero;
        logic             pos_zero;
        logic             sweep_done;
        logic             mod_done;
        logic             shuffle_last;
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_COPY,
        S_MOD,
        S_RD_J,
        S_SWAP_I,
        S_SWAP_J,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/ioshuf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ioshuf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/ioshuf_mod.sv -----
// Iterative remainder unit: random word mod (position + 1), four bits a cycle.
// Depends on ioshuf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ioshuf_mod
    import ioshuf_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [WORD_W-1:0]                   dividend,
    input  wire logic [$clog2(MAX_ELEMS + 1)-1:0]    divisor,
    output logic                                     done,
    output logic      [$clog2(MAX_ELEMS + 1)-1:0]    rem
);

    localparam int CNT_W   = $clog2(MAX_ELEMS + 1);
    localparam int RADIX_W = 4;
    localparam int STEPS   = (WORD_W + RADIX_W - 1) / RADIX_W;
    localparam int PAD_W   = STEPS * RADIX_W;
    localparam int STEP_W  = $clog2(STEPS);

    logic [PAD_W-1:0]  dividend_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;

    // Restoring division on the top bits of the dividend; remainder stays narrow.
    always_comb
    begin
        logic [CNT_W:0]   trial;
        logic [CNT_W-1:0] r;
        r = rem_reg;
        for (int b = 0; b < RADIX_W; b++)
        begin
            trial = {r, dividend_reg[PAD_W-1-b]};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial = trial - {1'b0, divisor_reg};
            end
            r = trial[CNT_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (run_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(STEPS - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= PAD_W'(dividend);
            divisor_reg  <= divisor;
            rem_reg      <= '0;
        end
        else if (run_reg)
        begin
            dividend_reg <= dividend_reg << RADIX_W;
            rem_reg      <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `ASSERT_IMP(a_rem_in_range, done_reg, rem_reg < divisor_reg, "remainder not below divisor")

endmodule

`default_nettype wire

// ----- rtl/core/ioshuf_dp.sv -----
// Datapath: original and working stores, counters, swap path, result register.
// Depends on ioshuf_pkg, ioshuf_ram, ioshuf_mod and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ioshuf_dp
    import ioshuf_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire ctrl_t   ctrl,
    input  wire item_t   item,
    output stat_t        stat,
    output logic         strobe,
    output result_t      result
);

    localparam int ADDR_W = $clog2(MAX_ELEMS);
    localparam int CNT_W  = $clog2(MAX_ELEMS + 1);

    item_t             item_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  len_next;
    logic [CNT_W-1:0]  lc_reg;
    logic [CNT_W-1:0]  lc_next;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  k_next;
    logic              shuffled_reg;
    logic              shuffled_next;
    logic              pend_reg;
    logic              pend_next;
    logic [ADDR_W-1:0] idx_reg;
    logic              last_reg;
    logic [DATA_W-1:0] tmp_reg;

    logic              lc_below;
    logic              k_at_len;
    logic              shuffle_last;
    logic [CNT_W-1:0]  k_minus1;
    logic [CNT_W-1:0]  k_plus1;
    logic [CNT_W-1:0]  pos_plus1;

    logic              mod_done;
    logic [CNT_W-1:0]  mod_rem;
    logic [ADDR_W-1:0] j_addr;

    logic              orig_we;
    logic [DATA_W-1:0] orig_rdata;
    logic              work_we;
    logic [ADDR_W-1:0] work_waddr;
    logic [DATA_W-1:0] work_wdata;
    logic [ADDR_W-1:0] work_raddr;
    logic [DATA_W-1:0] work_rdata;

    assign lc_below     = lc_reg < CNT_W'(MAX_ELEMS);
    assign k_at_len     = k_reg == len_reg;
    assign k_minus1     = k_reg - CNT_W'(1);
    assign k_plus1      = k_reg + CNT_W'(1);
    assign pos_plus1    = CNT_W'(pos_reg) + CNT_W'(1);
    assign shuffle_last = pos_plus1 >= len_reg;
    assign j_addr       = mod_rem[ADDR_W-1:0];

    ioshuf_mod #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.mod_start),
        .dividend (item_reg.random_word),
        .divisor  (pos_plus1),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign orig_we = (ctrl.op == OP_LOAD) && lc_below;

    ioshuf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMS)
    ) u_orig_ram (
        .clk   (clk),
        .we    (orig_we),
        .waddr (lc_reg[ADDR_W-1:0]),
        .wdata (item_reg.element_value),
        .raddr (k_reg[ADDR_W-1:0]),
        .rdata (orig_rdata)
    );

    always_comb
    begin
        work_we    = 1'b0;
        work_waddr = k_minus1[ADDR_W-1:0];
        work_wdata = orig_rdata;
        work_raddr = k_reg[ADDR_W-1:0];
        unique case (ctrl.op)
            OP_COPY:
            begin
                // orig read data is registered, so it belongs to the previous address
                work_we = k_reg != '0;
            end
            OP_RD_I:
            begin
                work_raddr = pos_reg;
            end
            OP_RD_J:
            begin
                work_raddr = j_addr;
            end
            OP_WR_I:
            begin
                work_we    = 1'b1;
                work_waddr = pos_reg;
                work_wdata = work_rdata;
            end
            OP_WR_J:
            begin
                work_we    = 1'b1;
                work_waddr = j_addr;
                work_wdata = tmp_reg;
            end
            default:
            begin
            end
        endcase
    end

    ioshuf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMS)
    ) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    always_comb
    begin
        len_next      = len_reg;
        lc_next       = lc_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        shuffled_next = shuffled_reg;
        unique case (ctrl.op)
            OP_LOAD:
            begin
                pos_next = '0;
                if (lc_below)
                begin
                    lc_next = lc_reg + CNT_W'(1);
                end
                if (item_reg.load_last)
                begin
                    len_next = lc_next;
                    lc_next  = '0;
                end
                else
                begin
                    len_next = '0;
                end
            end
            OP_EMIT_START:
            begin
                pos_next      = '0;
                k_next        = '0;
                shuffled_next = 1'b0;
            end
            OP_COPY_START:
            begin
                k_next = '0;
            end
            OP_COPY, OP_EMIT:
            begin
                if (!k_at_len)
                begin
                    k_next = k_plus1;
                end
            end
            OP_WR_J:
            begin
                if (shuffle_last)
                begin
                    pos_next      = '0;
                    k_next        = '0;
                    shuffled_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + ADDR_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pend_next = (ctrl.op == OP_EMIT) && !k_at_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            lc_reg       <= '0;
            pos_reg      <= '0;
            k_reg        <= '0;
            shuffled_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            lc_reg       <= lc_next;
            pos_reg      <= pos_next;
            k_reg        <= k_next;
            shuffled_reg <= shuffled_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_CAPTURE)
        begin
            item_reg <= item;
        end
        if (ctrl.op == OP_RD_J)
        begin
            tmp_reg <= work_rdata;
        end
        if (ctrl.op == OP_EMIT)
        begin
            idx_reg  <= k_reg[ADDR_W-1:0];
            last_reg <= k_plus1 == len_reg;
        end
    end

    always_comb
    begin
        stat.cmd          = item_reg.cmd;
        stat.len_zero     = len_reg == '0;
        stat.pos_zero     = pos_reg == '0;
        stat.sweep_done   = k_at_len;
        stat.mod_done     = mod_done;
        stat.shuffle_last = shuffle_last;
    end

    assign strobe              = pend_reg;
    assign result.out_value    = shuffled_reg ? work_rdata : orig_rdata;
    assign result.out_index    = IDX_W'(idx_reg);
    assign result.out_shuffled = shuffled_reg;
    assign result.out_last     = last_reg;

    `ASSERT_HOLDS(a_load_count_bound, lc_reg <= CNT_W'(MAX_ELEMS), "load count past store size")
    `ASSERT_NEXT(a_last_ends_burst, pend_reg && last_reg, !pend_reg, "result after final element")

endmodule

`default_nettype wire

// ----- rtl/core/ioshuf_ctrl.sv -----
// Controller state machine: decodes each transaction and sequences the datapath.
// Depends on ioshuf_pkg.
`default_nettype none

module ioshuf_ctrl
    import ioshuf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    output logic       busy,
    output ctrl_t      ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_EMIT:
                    begin
                        state_next = stat.len_zero ? S_IDLE : S_EMIT;
                    end
                    CMD_SHUFFLE:
                    begin
                        if (stat.len_zero)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = stat.pos_zero ? S_COPY : S_MOD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_COPY:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_RD_J;
                end
            end
            S_RD_J:
            begin
                state_next = S_SWAP_I;
            end
            S_SWAP_I:
            begin
                state_next = S_SWAP_J;
            end
            S_SWAP_J:
            begin
                state_next = stat.shuffle_last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy           = state_reg != S_IDLE;
        ctrl.op        = OP_NONE;
        ctrl.mod_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.op = OP_CAPTURE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_LOAD:
                    begin
                        ctrl.op = OP_LOAD;
                    end
                    CMD_EMIT:
                    begin
                        ctrl.op = OP_EMIT_START;
                    end
                    CMD_SHUFFLE:
                    begin
                        // start the remainder now; it runs alongside the store copy
                        if (!stat.len_zero)
                        begin
                            ctrl.mod_start = 1'b1;
                            ctrl.op        = stat.pos_zero ? OP_COPY_START : OP_NONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_COPY:
            begin
                ctrl.op = OP_COPY;
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    ctrl.op = OP_RD_I;
                end
            end
            S_RD_J:
            begin
                ctrl.op = OP_RD_J;
            end
            S_SWAP_I:
            begin
                ctrl.op = OP_WR_I;
            end
            S_SWAP_J:
            begin
                ctrl.op = OP_WR_J;
            end
            S_EMIT:
            begin
                ctrl.op = OP_EMIT;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/inside_out_random_shuffle.sv -----
// Channel   Ports                    Transaction
// input     start, busy, item        accepted when start is high and busy is low
// result    strobe, result           one element per strobe cycle, cannot be held off
//
// A load captures the item and then stores the element. Emit original sends the
// N elements of the array. A shuffle step is paced by the remainder unit (4 bits a
// cycle) and the single read port of the working store; the first step of a shuffle
// also copies the store, alongside the remainder. The last step then emits N
// results, one per cycle, before busy drops. Reset clears all control state;
// the stores hold no reset value. Results leave on fixed cycles.
// Depends on ioshuf_pkg, ioshuf_ctrl, ioshuf_dp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module inside_out_random_shuffle
    import ioshuf_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    output logic       busy,
    output logic       strobe,
    output result_t    result
);

    ctrl_t ctrl;
    stat_t stat;

    ioshuf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    ioshuf_dp #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .stat   (stat),
        .strobe (strobe),
        .result (result)
    );

    `ASSERT_IMP(a_strobe_busy, strobe, busy, "result outside a transaction")
    `ASSERT_NEXT(a_index_step, strobe && !result.out_last, strobe && (result.out_index == $past(result.out_index) + IDX_W'(1)), "emission gap or index skip")

endmodule

`default_nettype wire
